// ===== hw/rtl/vsa_pkg.sv =====
// Shared constants and types for the voice slot allocator.
package vsa_pkg;

    localparam int VOICES     = 8;
    localparam int STAMP_BITS = 64;
    localparam int IDX_W      = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CH_W       = 5;
    localparam int SLOT_W     = 3;
    localparam int CMP_W      = (IDX_W > CH_W) ? IDX_W : CH_W;
    localparam int IDXE_W     = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 8;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Search state handed from one cell to the next.
    typedef struct packed {
        logic                  valid;
        logic                  free;
        logic                  has;
        logic [IDX_W-1:0]      idx;
        logic [STAMP_BITS-1:0] stamp;
    } t_carry;

    // Broadcast that marks a slot busy and restamps it.
    typedef struct packed {
        logic                  en;
        logic [IDX_W-1:0]      idx;
        logic [STAMP_BITS-1:0] stamp;
    } t_wr;

    // Broadcast that clears the busy flag of a channel.
    typedef struct packed {
        logic            en;
        logic [CH_W-1:0] ch;
    } t_clr;

endpackage

// ===== hw/rtl/vsa_cell.sv =====
// One voice slot: busy flag, stamp and one stage of the slot search.
module vsa_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [vsa_pkg::IDX_W-1:0]   i_index,
    input  vsa_pkg::t_carry             i_carry,
    input  vsa_pkg::t_wr                i_wr,
    input  vsa_pkg::t_clr               i_clr,
    output vsa_pkg::t_carry             o_carry,
    output logic                        o_busy
);

    logic                           r_busy;
    logic                           n_busy;
    logic [vsa_pkg::STAMP_BITS-1:0] r_stamp;
    logic [vsa_pkg::STAMP_BITS-1:0] n_stamp;
    logic                           r_cvalid;
    vsa_pkg::t_carry                r_carry;
    vsa_pkg::t_carry                n_carry;
    logic                           wr_hit;
    logic                           clr_hit;
    logic                           take_free;
    logic                           take_old;

    assign wr_hit  = i_wr.en && (i_wr.idx == i_index);
    assign clr_hit = i_clr.en &&
                     (vsa_pkg::CMP_W'(i_clr.ch) == vsa_pkg::CMP_W'(i_index));

    assign take_free = !i_carry.free && !r_busy;
    assign take_old  = !i_carry.free && r_busy &&
                       (!i_carry.has || (r_stamp < i_carry.stamp));

    always_comb begin
        n_busy  = r_busy;
        n_stamp = r_stamp;
        if (wr_hit) begin
            n_busy  = 1'b1;
            n_stamp = i_wr.stamp;
        end else if (clr_hit) begin
            n_busy = 1'b0;
        end
    end

    always_comb begin
        n_carry = i_carry;
        if (take_free) begin
            n_carry.free  = 1'b1;
            n_carry.has   = 1'b1;
            n_carry.idx   = i_index;
            n_carry.stamp = r_stamp;
        end else if (take_old) begin
            n_carry.has   = 1'b1;
            n_carry.idx   = i_index;
            n_carry.stamp = r_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_stamp  <= '0;
            r_cvalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_stamp  <= n_stamp;
            r_cvalid <= i_carry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
    end

    always_comb begin
        o_carry       = r_carry;
        o_carry.valid = r_cvalid;
    end

    assign o_busy = r_busy;

endmodule

// ===== hw/rtl/vsa_ctrl.sv =====
// Request handshake, sequence counter, commit and result register.
module vsa_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [vsa_pkg::S_TDATA_W-1:0]     i_s_tdata,
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [vsa_pkg::M_TDATA_W-1:0]     o_m_tdata,
    output logic                              o_m_tuser,
    output vsa_pkg::t_carry                   o_start,
    input  vsa_pkg::t_carry                   i_last,
    output vsa_pkg::t_wr                      o_wr,
    output vsa_pkg::t_clr                     o_clr
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_COMMIT = 3'b100
    } t_state;

    t_state                         r_state;
    t_state                         n_state;
    logic [vsa_pkg::STAMP_BITS-1:0] r_count;
    logic [vsa_pkg::STAMP_BITS-1:0] n_count;
    logic [vsa_pkg::IDX_W-1:0]      r_pick;
    logic                           r_found;
    logic                           r_ovalid;
    logic [vsa_pkg::SLOT_W-1:0]     r_oslot;
    logic                           r_oevict;
    logic [vsa_pkg::IDXE_W-1:0]     pick_ext;
    logic                           accept;
    logic                           commit;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign commit     = (r_state == ST_COMMIT) && (!r_ovalid || i_m_tready);
    assign n_count    = r_count + vsa_pkg::STAMP_BITS'(1);
    assign pick_ext   = vsa_pkg::IDXE_W'(r_pick);

    always_comb begin
        o_start       = '0;
        o_start.valid = accept && (i_s_tuser == vsa_pkg::REQ_ALLOC);
    end

    always_comb begin
        o_clr.en = accept && (i_s_tuser == vsa_pkg::REQ_FREE);
        o_clr.ch = i_s_tdata[vsa_pkg::CH_W-1:0];
    end

    always_comb begin
        o_wr.en    = commit;
        o_wr.idx   = r_pick;
        o_wr.stamp = n_count;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_s_tuser == vsa_pkg::REQ_ALLOC)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_last.valid) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_count  <= n_count;
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_SCAN) && i_last.valid) begin
            r_pick  <= i_last.idx;
            r_found <= i_last.free;
        end
        if (commit) begin
            r_oslot  <= pick_ext[vsa_pkg::SLOT_W-1:0];
            r_oevict <= !r_found;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = vsa_pkg::M_TDATA_W'(r_oslot);
    assign o_m_tuser  = r_oevict;

endmodule

// ===== hw/rtl/voice_slot_allocator.sv =====
// Top level of the voice slot allocator: control unit and chain of slot cells.
//
// Requests arrive on the slave stream. tuser carries the request kind (0 allocates
// a slot, 1 frees one) and tdata carries the channel number to free. A free
// transaction clears the busy flag of that slot; channel numbers beyond the
// pool are ignored and no result is sent.
// An allocate transaction sends a search token down the chain of slot cells, one
// cell per cycle. The token keeps the first free slot, or else the oldest stamp
// with the lowest index on a tie. After the last cell the slot is marked busy,
// restamped from the sequence counter, and the result is loaded into the output
// register. The master stream returns the slot in tdata and the eviction flag in
// tuser. The time from acceptance to a valid result is set by the length of the
// cell chain; the next request is taken once the result has been committed.
// While a result waits on a stalled receiver, further free requests are taken;
// a further allocate finishes its search and holds its commit until the output
// register is free. Reset clears all busy flags, the counter and the output.
module voice_slot_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [vsa_pkg::S_TDATA_W-1:0] i_s_tdata,  // [4:0] channel, [7:5] zero
    input  logic                          i_s_tuser,  // [0] req_type
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [vsa_pkg::M_TDATA_W-1:0] o_m_tdata,  // [2:0] slot, [7:3] zero
    output logic                          o_m_tuser   // [0] evicted
);

    vsa_pkg::t_carry             carry [0:vsa_pkg::VOICES];
    vsa_pkg::t_wr                wr;
    vsa_pkg::t_clr               clr;
    logic [vsa_pkg::VOICES-1:0]  busy;
    logic [vsa_pkg::VOICES:0]    cvalid;

    vsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_start    (carry[0]),
        .i_last     (carry[vsa_pkg::VOICES]),
        .o_wr       (wr),
        .o_clr      (clr)
    );

    for (genvar gi = 0; gi < vsa_pkg::VOICES; gi++) begin : g_cell
        vsa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (vsa_pkg::IDX_W'(gi)),
            .i_carry (carry[gi]),
            .i_wr    (wr),
            .i_clr   (clr),
            .o_carry (carry[gi+1]),
            .o_busy  (busy[gi])
        );
    end

    for (genvar gv = 0; gv <= vsa_pkg::VOICES; gv++) begin : g_cvalid
        assign cvalid[gv] = carry[gv].valid;
    end

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cvalid))
        else $error("more than one search token in the cell chain");

    a_idle_no_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (cvalid[vsa_pkg::VOICES:1] == '0))
        else $error("request port ready while a search is in flight");

    a_evict_all_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !$past(o_m_tvalid) && o_m_tuser) |-> $past(&busy))
        else $error("eviction reported while a slot was free");

endmodule

// ===== tb/tb_voice_slot_allocator.sv =====
// Self-checking testbench for the voice slot allocator with a first-free, else oldest, grant scoreboard.
module tb_voice_slot_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1650;

    typedef struct packed {
        logic [vsa_pkg::SLOT_W-1:0] slot;
        logic                       evicted;
    } t_grant;

    class slot_scoreboard;
        bit                             busy[vsa_pkg::VOICES];
        logic [vsa_pkg::STAMP_BITS-1:0] stamps[vsa_pkg::VOICES];
        logic [vsa_pkg::STAMP_BITS-1:0] seq;
        t_grant                         grants_due[$];
        int                             errors;

        function new();
            for (int i = 0; i < vsa_pkg::VOICES; i++) begin
                busy[i]   = 1'b0;
                stamps[i] = '0;
            end
            seq    = '0;
            errors = 0;
        endfunction

        function void note_request(logic req, logic [vsa_pkg::CH_W-1:0] ch);
            int     pick;
            bit     found;
            t_grant g;
            if (req == vsa_pkg::REQ_FREE) begin
                if (ch < vsa_pkg::VOICES) busy[ch] = 1'b0;
                return;
            end
            pick  = 0;
            found = 1'b0;
            for (int i = 0; i < vsa_pkg::VOICES; i++) begin
                if (!found && !busy[i]) begin
                    pick  = i;
                    found = 1'b1;
                end
            end
            if (!found) begin
                for (int i = 1; i < vsa_pkg::VOICES; i++) begin
                    if (stamps[i] < stamps[pick]) pick = i;
                end
            end
            seq          = seq + 1'b1;
            busy[pick]   = 1'b1;
            stamps[pick] = seq;
            g.slot       = pick[vsa_pkg::SLOT_W-1:0];
            g.evicted    = !found;
            grants_due.push_back(g);
        endfunction

        function void check_grant(logic [vsa_pkg::SLOT_W-1:0] slot, logic evicted);
            t_grant g;
            if (grants_due.size() == 0) begin
                $display("%0t: unexpected grant expected=none actual slot=%0d evicted=%0d",
                         $time, slot, evicted);
                errors++;
                return;
            end
            g = grants_due.pop_front();
            if (slot !== g.slot) begin
                $display("%0t: slot mismatch expected=%0d actual=%0d", $time, g.slot, slot);
                errors++;
            end
            if (evicted !== g.evicted) begin
                $display("%0t: evicted mismatch expected=%0d actual=%0d",
                         $time, g.evicted, evicted);
                errors++;
            end
        endfunction

        function int pending();
            return grants_due.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    logic [vsa_pkg::S_TDATA_W-1:0] i_s_tdata;  // [4:0] channel, [7:5] zero
    logic                          i_s_tuser;  // [0] req_type
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    logic [vsa_pkg::M_TDATA_W-1:0] o_m_tdata;  // [2:0] slot, [7:3] zero
    logic                          o_m_tuser;  // [0] evicted

    slot_scoreboard sb;
    int             cycles;
    bit             tx_calm;

    voice_slot_allocator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL voice_slot_allocator");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_grant(o_m_tdata[vsa_pkg::SLOT_W-1:0], o_m_tuser);
        end
    end

    // The receiver alternates between stretches that never stall and stretches of random stalls.
    initial begin
        int  hold;
        int  r;
        bit  rx_calm;
        i_m_tready = 1'b0;
        hold       = 0;
        rx_calm    = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
            if (hold > 0) begin
                hold--;
            end else if (rx_calm) begin
                i_m_tready = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    i_m_tready = 1'b1;
                end else if (r < 90) begin
                    i_m_tready = 1'b0;
                    hold       = $urandom_range(0, 2);
                end else begin
                    i_m_tready = 1'b0;
                    hold       = $urandom_range(5, 30);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (tx_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_request(input logic req, input logic [vsa_pkg::CH_W-1:0] ch);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = req;
        i_s_tdata  = {{(vsa_pkg::S_TDATA_W-vsa_pkg::CH_W){1'b0}}, ch};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(req, ch);
    endtask

    task automatic allocate_one();
        send_request(vsa_pkg::REQ_ALLOC, vsa_pkg::CH_W'($urandom_range(0, 23)));
    endtask

    initial begin
        int  done;
        int  kind;
        int  n;
        logic [vsa_pkg::CH_W-1:0] ch;
        sb         = new();
        tx_calm    = 1'b0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tuser  = vsa_pkg::REQ_ALLOC;
        i_s_tdata  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill the pool, evict the two oldest, free busy, idle and unknown channels, then mix allocates and frees.
        for (int i = 0; i < vsa_pkg::VOICES; i++) begin
            send_request(vsa_pkg::REQ_ALLOC,
                         (i % 2) ? vsa_pkg::CH_W'(23) : vsa_pkg::CH_W'(0));
        end
        allocate_one();
        allocate_one();
        send_request(vsa_pkg::REQ_FREE, vsa_pkg::CH_W'(3));
        send_request(vsa_pkg::REQ_FREE, vsa_pkg::CH_W'(3));
        send_request(vsa_pkg::REQ_FREE, vsa_pkg::CH_W'(vsa_pkg::VOICES));
        send_request(vsa_pkg::REQ_FREE, vsa_pkg::CH_W'(23));
        send_request(vsa_pkg::REQ_FREE, vsa_pkg::CH_W'(16));
        allocate_one();
        allocate_one();
        send_request(vsa_pkg::REQ_FREE, vsa_pkg::CH_W'(7));
        send_request(vsa_pkg::REQ_FREE, vsa_pkg::CH_W'(0));
        allocate_one();
        allocate_one();
        allocate_one();

        done = 0;
        while (done < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) tx_calm = !tx_calm;
            kind = $urandom_range(0, 9);
            n    = $urandom_range(1, 12);
            for (int k = 0; k < n; k++) begin
                if (kind < 3) begin
                    allocate_one();
                end else if (kind < 7) begin
                    if ($urandom_range(0, 1)) begin
                        allocate_one();
                    end else begin
                        send_request(vsa_pkg::REQ_FREE,
                                     vsa_pkg::CH_W'($urandom_range(0, vsa_pkg::VOICES-1)));
                    end
                end else if (kind < 9) begin
                    send_request(vsa_pkg::REQ_FREE,
                                 vsa_pkg::CH_W'($urandom_range(0, vsa_pkg::VOICES-1)));
                end else begin
                    ch = vsa_pkg::CH_W'($urandom_range(0, 23));
                    send_request(vsa_pkg::REQ_FREE, ch);
                end
                done++;
            end
        end

        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (vsa_pkg::VOICES + 4) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS voice_slot_allocator");
        end else begin
            $display("FAIL voice_slot_allocator");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/vsa_pkg.sv
hw/rtl/vsa_cell.sv
hw/rtl/vsa_ctrl.sv
hw/rtl/voice_slot_allocator.sv
tb/tb_voice_slot_allocator.sv
